@@ src/akn_pkg.sv @@
// ----------------------------------------------------------------------------
// akn_pkg
// Shared types and constants for the k-of-n alarm confirmation block.
// ----------------------------------------------------------------------------
package akn_pkg;

  // default depth of the flag history chain
  localparam int unsigned MaxHistoryDef = 64;

  // field widths
  localparam int unsigned ScoreW   = 16;
  localparam int unsigned IndexW   = 32;
  localparam int unsigned TotalW   = 32;
  localparam int unsigned CfgNW    = 7;
  localparam int unsigned CfgKW    = 7;
  localparam int unsigned HoldW    = 8;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 3;

  // stream widths, padded to whole bytes
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 120;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegThreshold = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMode      = 3'd1;
  localparam logic [CfgIdxW-1:0] RegWindowN   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRequiredK = 3'd3;
  localparam logic [CfgIdxW-1:0] RegHoldoff   = 3'd4;

  // register reset values
  localparam logic signed [ScoreW-1:0] ThresholdRst = 16'sd9830;  // 0.60 in Q1.14
  localparam logic                     ModeRst      = 1'b0;
  localparam logic [CfgNW-1:0]         WindowNRst   = 7'd5;
  localparam logic [CfgKW-1:0]         RequiredKRst = 7'd5;
  localparam logic [HoldW-1:0]         HoldoffRst   = 8'd5;

  // mode codes
  localparam logic ModeAnyOfN = 1'b0;
  localparam logic ModeKOfN   = 1'b1;

  // control from the sequencer to the flag chain
  typedef struct packed {
    logic wr_en;   // write the new flag into its cell
    logic wr_bit;  // value of the new flag
    logic rotate;  // move every flag one cell towards the head
  } akn_chain_ctrl_t;

endpackage : akn_pkg

@@ src/alarm_k_of_n_confirm_cooldown.sv @@
// ----------------------------------------------------------------------------
// alarm_k_of_n_confirm_cooldown
// K-of-N abnormal window detection with hold-off after each confirmed alarm.
// ----------------------------------------------------------------------------
// Each score word gives one result word. On acceptance the new flag is written
// into the history chain; the scan then rotates the whole chain once past the
// counting tap at cell 0, and the decision step loads the output register. The
// result register frees the input side, so the next word may be taken while a
// result waits; a result held back by the sink stalls only the decision cycle.
// The history resets to all clear, so there is no start-up sweep. Configuration
// must be written only while the block is idle; the block itself does not
// enforce this.
module alarm_k_of_n_confirm_cooldown #(
  parameter int unsigned MaxHistory = akn_pkg::MaxHistoryDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // abnormal_score [15:0], window_end_index [47:16]
  input  logic [akn_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // score_echo [15:0], raw_flag [16], alarm_confirmed [17], window_index [49:18],
  // inference_total [81:50], confirmed_total [113:82], zero [119:114]
  output logic [akn_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic                         cfg_we_i,
  input  logic [akn_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [akn_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import akn_pkg::*;

  localparam int unsigned PosW  = (MaxHistory > 1) ? $clog2(MaxHistory) : 1;
  localparam int unsigned CntW  = $clog2(MaxHistory + 1);
  localparam int unsigned CmpW  = (CntW > CfgNW) ? CntW : CfgNW;
  localparam logic [PosW-1:0] LastStep = PosW'(MaxHistory - 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;

  // configuration
  logic signed [ScoreW-1:0] thr_q;
  logic                     mode_q;
  logic [CfgNW-1:0]         cfg_n_q;
  logic [CfgKW-1:0]         cfg_k_q;
  logic [HoldW-1:0]         hold_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= ThresholdRst;
      mode_q     <= ModeRst;
      cfg_n_q    <= WindowNRst;
      cfg_k_q    <= RequiredKRst;
      hold_cfg_q <= HoldoffRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegThreshold: thr_q      <= $signed(cfg_wdata_i);
        RegMode:      mode_q     <= cfg_wdata_i[0];
        RegWindowN:   cfg_n_q    <= cfg_wdata_i[CfgNW-1:0];
        RegRequiredK: cfg_k_q    <= cfg_wdata_i[CfgKW-1:0];
        RegHoldoff:   hold_cfg_q <= cfg_wdata_i[HoldW-1:0];
        default: ;
      endcase
    end
  end

  // effective n and k
  logic [CmpW-1:0] n_one, k_one, n_sel;
  logic [CntW-1:0] n_eff, k_eff;

  always_comb begin
    n_one = (cfg_n_q == '0) ? CmpW'(1) : CmpW'(cfg_n_q);
    n_sel = (n_one > CmpW'(MaxHistory)) ? CmpW'(MaxHistory) : n_one;
    n_eff = n_sel[CntW-1:0];
    k_one = (cfg_k_q == '0) ? CmpW'(1) : CmpW'(cfg_k_q);
    k_eff = (k_one > n_sel) ? n_eff : k_one[CntW-1:0];
  end

  // sequencer state
  logic [1:0]               state_q, state_d;
  logic [PosW-1:0]          step_q, step_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [PosW-1:0]          pos_q, pos_d;
  logic [CntW-1:0]          filled_q, filled_d;
  logic [HoldW-1:0]         hold_q, hold_d;
  logic [TotalW-1:0]        proc_q, proc_d;
  logic [TotalW-1:0]        alarm_q, alarm_d;
  logic                     m_valid_q, m_valid_d;

  // item payload held over the scan
  logic signed [ScoreW-1:0] score_q;
  logic [IndexW-1:0]        widx_q;
  logic                     raw_q;

  // result register
  logic signed [ScoreW-1:0] o_score_q;
  logic                     o_raw_q, o_conf_q;
  logic [IndexW-1:0]        o_widx_q;
  logic [TotalW-1:0]        o_proc_q, o_alarm_q;

  logic signed [ScoreW-1:0] in_score;
  logic [IndexW-1:0]        in_widx;
  logic                     in_raw, accept, out_load, cand, conf, head;
  logic [PosW-1:0]          wr_pos;
  logic [CntW-1:0]          pos_inc, filled_c;
  akn_chain_ctrl_t          chain_ctrl;

  assign in_score      = $signed(s_axis_tdata[ScoreW-1:0]);
  assign in_widx       = s_axis_tdata[ScoreW +: IndexW];
  assign in_raw        = in_score > thr_q;
  assign s_axis_tready = (state_q == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == StOut) && (!m_valid_q || m_axis_tready);

  assign wr_pos   = (CntW'(pos_q) < n_eff) ? pos_q : '0;
  assign pos_inc  = CntW'(wr_pos) + CntW'(1);
  assign filled_c = (filled_q > n_eff) ? n_eff : filled_q;

  assign cand = (mode_q == ModeAnyOfN) ? (cnt_q != '0) : (cnt_q >= k_eff);
  assign conf = (hold_q == '0) && cand;

  assign chain_ctrl.wr_en  = accept;
  assign chain_ctrl.wr_bit = in_raw;
  assign chain_ctrl.rotate = (state_q == StScan);

  akn_flag_chain #(
    .MaxHistory (MaxHistory)
  ) u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (chain_ctrl),
    .wr_pos_i (wr_pos),
    .head_o   (head)
  );

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    filled_d  = filled_q;
    hold_d    = hold_q;
    proc_d    = proc_q;
    alarm_d   = alarm_q;
    m_valid_d = m_valid_q && !m_axis_tready;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          pos_d    = (pos_inc >= n_eff) ? '0 : pos_inc[PosW-1:0];
          filled_d = (filled_c < n_eff) ? filled_c + CntW'(1) : filled_c;
          step_d   = '0;
          cnt_d    = '0;
          state_d  = StScan;
        end
      end
      StScan: begin
        // the tap sees ring entry step_q on this cycle
        if ((CntW'(step_q) < filled_q) && head) begin
          cnt_d = cnt_q + CntW'(1);
        end
        step_d = step_q + PosW'(1);
        if (step_q == LastStep) begin
          step_d  = '0;
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_load) begin
          if (hold_q != '0) begin
            hold_d = hold_q - HoldW'(1);
          end else if (cand) begin
            hold_d = hold_cfg_q;
          end
          proc_d    = proc_q + TotalW'(1);
          alarm_d   = conf ? alarm_q + TotalW'(1) : alarm_q;
          m_valid_d = 1'b1;
          state_d   = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      step_q    <= '0;
      cnt_q     <= '0;
      pos_q     <= '0;
      filled_q  <= '0;
      hold_q    <= '0;
      proc_q    <= '0;
      alarm_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      cnt_q     <= cnt_d;
      pos_q     <= pos_d;
      filled_q  <= filled_d;
      hold_q    <= hold_d;
      proc_q    <= proc_d;
      alarm_q   <= alarm_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      score_q <= in_score;
      widx_q  <= in_widx;
      raw_q   <= in_raw;
    end
    if (out_load) begin
      o_score_q <= score_q;
      o_raw_q   <= raw_q;
      o_conf_q  <= conf;
      o_widx_q  <= widx_q;
      o_proc_q  <= proc_d;
      o_alarm_q <= alarm_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'b0, o_alarm_q, o_proc_q, o_widx_q, o_conf_q, o_raw_q,
                          o_score_q};

  // ------------------------------------------------------------------------
  // assertions

  // a running hold-off never lets an alarm through
  a_hold_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (hold_q != '0)) |=> (m_axis_tvalid && !m_axis_tdata[17]))
    else $error("alarm confirmed during hold-off");

  // the count gathered over the scan never exceeds the filled entries
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut) |-> (cnt_q <= filled_q))
    else $error("flag count above filled entries");

  // one full rotation ends the scan
  a_scan_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StScan) && (step_q == LastStep)) |=> (state_q == StOut))
    else $error("scan did not end after one rotation");

  // the history never claims more entries than the chain holds
  a_filled_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= CntW'(MaxHistory))
    else $error("filled count beyond chain depth");

endmodule : alarm_k_of_n_confirm_cooldown

@@ src/akn_cell.sv @@
// ----------------------------------------------------------------------------
// akn_cell
// One history cell: holds one abnormal flag, loads a new flag or takes its
// neighbour's flag during a rotation.
// ----------------------------------------------------------------------------
module akn_cell (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_en_i,
  input  logic wr_bit_i,
  input  logic rotate_i,
  input  logic nbr_i,
  output logic flag_o
);

  logic flag_q, flag_d;

  always_comb begin
    flag_d = flag_q;
    if (wr_en_i) begin
      flag_d = wr_bit_i;
    end else if (rotate_i) begin
      flag_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else begin
      flag_q <= flag_d;
    end
  end

  assign flag_o = flag_q;

endmodule : akn_cell

@@ src/akn_flag_chain.sv @@
// ----------------------------------------------------------------------------
// akn_flag_chain
// Ring of history cells. A new flag is written at its ring position; a
// rotation moves every flag one cell towards cell 0, whose flag is the tap.
// ----------------------------------------------------------------------------
module akn_flag_chain #(
  parameter int unsigned MaxHistory = akn_pkg::MaxHistoryDef,
  localparam int unsigned PosW = (MaxHistory > 1) ? $clog2(MaxHistory) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  akn_pkg::akn_chain_ctrl_t ctrl_i,
  input  logic [PosW-1:0]         wr_pos_i,
  output logic                    head_o
);
  import akn_pkg::*;

  logic [MaxHistory-1:0] flags;

  for (genvar i = 0; i < MaxHistory; i++) begin : g_cell
    akn_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .wr_en_i  (ctrl_i.wr_en && (wr_pos_i == PosW'(i))),
      .wr_bit_i (ctrl_i.wr_bit),
      .rotate_i (ctrl_i.rotate),
      .nbr_i    (flags[(i + 1) % MaxHistory]),
      .flag_o   (flags[i])
    );
  end

  assign head_o = flags[0];

endmodule : akn_flag_chain
